FILE: hdl/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, field widths and command / status codes of the indexed list
// store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int FUNC_W       = 3;
  localparam int STAT_W       = 2;
  localparam int CNT_OUT_W    = 5;
  localparam int DEF_CAPACITY = 16;

  // command codes
  localparam logic [FUNC_W-1:0] FN_GET  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_AT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_OUT_W-1:0]     count_now;
  } out_t;

endpackage

FILE: hdl/ils_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ils_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_seq
// Command sequencer: decodes one command word, then walks the element
// memory one move at a time with a shared index step and compare.
// ----------------------------------------------------------------------------
module ils_seq #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ils_pkg::in_t                in_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ils_pkg::out_t               res_data,
  output logic                        we,
  output logic [$clog2(CAPACITY)-1:0] waddr,
  output logic [ils_pkg::DATA_W-1:0]  wdata,
  output logic [$clog2(CAPACITY)-1:0] raddr,
  input  logic [ils_pkg::DATA_W-1:0]  rdata
);
  import ils_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GET  = 5'b00010,
    S_SHR  = 5'b00100,
    S_SHW  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     lim, lim_next;
  logic              ins, ins_next;
  logic [DATA_W-1:0] val, val_next;
  logic [DATA_W-1:0] rd_val, rd_val_next;
  logic [STAT_W-1:0] st, st_next;

  logic [CW-1:0]    step;
  logic             pos_neg;
  logic [POS_W-1:0] pos_u;
  logic [POS_W-1:0] cnt_w;
  logic             pos_ok;
  logic [POS_W-1:0] ins_p;
  logic             full;

  // shared index unit: one step up or down the list
  assign step    = ins ? (idx - CW'(1)) : (idx + CW'(1));
  assign pos_neg = in_data.position[POS_W-1];
  assign pos_u   = POS_W'(in_data.position);
  assign cnt_w   = POS_W'(count);
  assign pos_ok  = !pos_neg && (pos_u < cnt_w);
  assign full    = (count >= CW'(CAPACITY));

  always_comb begin
    case (in_data.func)
      FN_HEAD: ins_p = '0;
      FN_TAIL: ins_p = cnt_w;
      default: ins_p = pos_neg ? '0 : pos_u;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res_data  = '{read_value: rd_val, status: st, count_now: CNT_OUT_W'(count)};

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    lim_next    = lim;
    ins_next    = ins;
    val_next    = val;
    rd_val_next = rd_val;
    st_next     = st;
    we          = 1'b0;
    waddr       = idx[AW-1:0];
    wdata       = val;
    raddr       = step[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next    = in_data.value;
          rd_val_next = '0;
          st_next     = ST_OK;
          state_next  = S_FIN;
          case (in_data.func)
            FN_GET: begin
              if (pos_ok) begin
                raddr      = pos_u[AW-1:0];
                state_next = S_GET;
              end else begin
                rd_val_next = '1;
                st_next     = ST_RANGE;
              end
            end
            FN_HEAD, FN_TAIL, FN_AT: begin
              // range test ahead of the full test
              if (ins_p > cnt_w) begin
                st_next = ST_RANGE;
              end else if (full) begin
                st_next = ST_FULL;
              end else begin
                ins_next   = 1'b1;
                idx_next   = count;
                lim_next   = CW'(ins_p);
                state_next = S_SHR;
              end
            end
            FN_DEL: begin
              if (pos_ok) begin
                ins_next   = 1'b0;
                idx_next   = CW'(pos_u);
                lim_next   = count - CW'(1);
                state_next = S_SHR;
              end else begin
                st_next = ST_RANGE;
              end
            end
            default: begin
              st_next = ST_RANGE;
            end
          endcase
        end
      end
      S_GET: begin
        rd_val_next = rdata;
        state_next  = S_FIN;
      end
      S_SHR: begin
        // read of the neighbour goes out on raddr, written back next cycle
        if (idx == lim) begin
          if (ins) begin
            we         = 1'b1;
            count_next = count + CW'(1);
          end else begin
            count_next = count - CW'(1);
          end
          state_next = S_FIN;
        end else begin
          state_next = S_SHW;
        end
      end
      S_SHW: begin
        we         = 1'b1;
        wdata      = rdata;
        idx_next   = step;
        state_next = S_SHR;
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    lim    <= lim_next;
    ins    <= ins_next;
    val    <= val_next;
    rd_val <= rd_val_next;
    st     <= st_next;
  end

endmodule

FILE: hdl/indexed_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed 32-bit values with get, insert and delete commands.
//
//   channel | ports                          | word
//   --------+--------------------------------+-----------------------------
//   command | in_valid, in_ready, in_data    | func, position, value
//   result  | out_valid, out_ready, out_data | read_value, status, count_now
//
// get reads one element; a rejected command goes straight to the result; an insert
// or delete moves the elements between the position and the list end one by one.
// each move is a read then a write through the element memory's read and write ports.
// synchronous reset empties the list; memory contents are not cleared.
// a stalled result sits in the output register; the sequencer holds its last
// word until that register is free, and takes no command meanwhile.
// ----------------------------------------------------------------------------
module indexed_list_store_core #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ils_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ils_pkg::out_t out_data
);
  import ils_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid;
  logic              res_ready;
  out_t              res_data;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  ils_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  ils_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule
